[sv/can_mask_filter_compiler_defines.svh]
// assertion macros for the mask filter compiler checker
// used by cmf_checker.sv, relies on clk and rst_n in the including scope
`ifndef CAN_MASK_FILTER_COMPILER_DEFINES_SVH
`define CAN_MASK_FILTER_COMPILER_DEFINES_SVH

// same-cycle implication
`define CMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmf check failed");

// next-cycle implication
`define CMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmf check failed");

`endif

[sv/cmf_pkg.sv]
// types, constants and helper functions of the mask filter compiler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

  localparam int BANKS  = 8;
  localparam int IDX_W  = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int CNT_W  = $clog2(BANKS + 1);
  localparam int ID_W   = 11;
  localparam int BASE_W = 6;
  localparam int BIDX_W = 7;
  localparam int POP_W  = 4;

  typedef struct packed {
    logic            rule_active;
    logic [ID_W-1:0] rule_id;
    logic [ID_W-1:0] rule_mask;
    logic            rule_remote;
    logic            last_rule;
  } in_item_t;

  typedef struct packed {
    logic [BIDX_W-1:0] bank_index;
    logic [ID_W-1:0]   filter_id;
    logic [ID_W-1:0]   filter_mask;
    logic              filter_remote;
    logic              fallback_used;
    logic              last_bank;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] mask;
    logic            remote;
  } slot_t;

  // true if o accepts everything that n accepts
  function automatic logic covers(slot_t o, slot_t n);
    return (o.remote == n.remote) && ((o.mask & ~n.mask) == '0) &&
           (((o.id ^ n.id) & o.mask) == '0);
  endfunction

  function automatic logic [ID_W-1:0] merged_mask(slot_t a, slot_t b);
    return a.mask & b.mask & ~(a.id ^ b.id);
  endfunction

  function automatic slot_t merge_into(slot_t a, slot_t b);
    slot_t r;
    r.mask   = merged_mask(a, b);
    r.id     = a.id & r.mask;
    r.remote = a.remote;
    return r;
  endfunction

  function automatic logic [POP_W-1:0] pop(logic [ID_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int k = 0; k < ID_W; k++) begin
      n = n + POP_W'(v[k]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/can_mask_filter_compiler.sv]
// top level of the receive rule to mask filter compiler
// uses cmf_pkg and cmf_ram (filter table)
// channel | ports                         | handshake
// in      | start, busy, in_item          | taken when start && !busy
// out     | out_valid, out_item           | one-cycle strobe, no back pressure
// cfg     | cfg_valid, cfg_ready, cfg_data| written when valid && ready
// each rule runs a sequencer over the filter table ram, one read per step:
// a scan of the stored entries, a compaction pass and a pair search;
// a last rule adds the bank output, one entry per bank.
// reset (rst_n low, synchronous) empties the table; table entries are not cleared
// results cannot be stalled; each bank entry follows its own table read
`timescale 1ns / 1ps
`default_nettype none

module can_mask_filter_compiler (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire cmf_pkg::in_item_t           in_item,
  output logic                             out_valid,
  output cmf_pkg::out_item_t               out_item,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cmf_pkg::BASE_W-1:0]  cfg_data
);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FINISH  = 5'd1;
  localparam logic [4:0] S_SCAN_RD = 5'd2;
  localparam logic [4:0] S_SCAN_EV = 5'd3;
  localparam logic [4:0] S_BEST_RD = 5'd4;
  localparam logic [4:0] S_BEST_EV = 5'd5;
  localparam logic [4:0] S_PA_RD   = 5'd6;
  localparam logic [4:0] S_PA_LD   = 5'd7;
  localparam logic [4:0] S_PB_RD   = 5'd8;
  localparam logic [4:0] S_PB_EV   = 5'd9;
  localparam logic [4:0] S_RM      = 5'd10;
  localparam logic [4:0] S_RM_WR   = 5'd11;
  localparam logic [4:0] S_CI_RD   = 5'd12;
  localparam logic [4:0] S_CI_LD   = 5'd13;
  localparam logic [4:0] S_CJ_RD   = 5'd14;
  localparam logic [4:0] S_CJ_EV   = 5'd15;
  localparam logic [4:0] S_EM_RD   = 5'd16;
  localparam logic [4:0] S_EM_OUT  = 5'd17;

  // where a removal returns to
  localparam logic [1:0] R_PAIR = 2'd0;
  localparam logic [1:0] R_CJ   = 2'd1;
  localparam logic [1:0] R_CI   = 2'd2;

  localparam int CW = cmf_pkg::CNT_W;
  localparam int IW = cmf_pkg::IDX_W;
  localparam logic [CW-1:0] BANKS_C = CW'(cmf_pkg::BANKS);

  logic [4:0]                   state_r, state_nxt;
  logic [cmf_pkg::BASE_W-1:0]   base_r, base_nxt;
  cmf_pkg::slot_t               rule_r, rule_nxt;
  logic                         last_r, last_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         need_d_r, need_d_nxt;
  logic                         need_rm_r, need_rm_nxt;
  logic                         failed_r, failed_nxt;
  logic [CW-1:0]                i_r, i_nxt;
  logic [CW-1:0]                j_r, j_nxt;
  cmf_pkg::slot_t               a_r, a_nxt;
  logic                         found_r, found_nxt;
  logic [IW-1:0]                bl_r, bl_nxt;
  logic [IW-1:0]                br_r, br_nxt;
  logic [cmf_pkg::POP_W-1:0]    bs_r, bs_nxt;
  cmf_pkg::slot_t               ba_r, ba_nxt;
  cmf_pkg::slot_t               bb_r, bb_nxt;
  logic                         append_r, append_nxt;  // append rule after compaction
  logic [IW-1:0]                rmk_r, rmk_nxt;
  logic [1:0]                   rmret_r, rmret_nxt;
  logic                         fb_r, fb_nxt;
  logic                         nd_r, nd_nxt;
  logic [CW-1:0]                n_r, n_nxt;
  logic [IW-1:0]                ei_r, ei_nxt;
  logic [IW-1:0]                ek_r, ek_nxt;
  logic                         ov_r, ov_nxt;
  cmf_pkg::out_item_t           oi_r, oi_nxt;

  // ram port
  logic                         we;
  logic [IW-1:0]                waddr;
  cmf_pkg::slot_t               wdata;
  logic [IW-1:0]                raddr;
  cmf_pkg::slot_t               rdata;

  logic [CW-1:0]                cnt_dec;
  logic [cmf_pkg::POP_W-1:0]    score;

  cmf_ram #(
    .WIDTH ($bits(cmf_pkg::slot_t)),
    .DEPTH (cmf_pkg::BANKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_item  = oi_r;
  assign cnt_dec   = cnt_r - CW'(1);

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    rule_nxt    = rule_r;
    last_nxt    = last_r;
    cnt_nxt     = cnt_r;
    need_d_nxt  = need_d_r;
    need_rm_nxt = need_rm_r;
    failed_nxt  = failed_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    a_nxt       = a_r;
    found_nxt   = found_r;
    bl_nxt      = bl_r;
    br_nxt      = br_r;
    bs_nxt      = bs_r;
    ba_nxt      = ba_r;
    bb_nxt      = bb_r;
    append_nxt  = append_r;
    rmk_nxt     = rmk_r;
    rmret_nxt   = rmret_r;
    fb_nxt      = fb_r;
    nd_nxt      = nd_r;
    n_nxt       = n_r;
    ei_nxt      = ei_r;
    ek_nxt      = ek_r;
    ov_nxt      = 1'b0;
    oi_nxt      = oi_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rule_r;
    raddr       = '0;
    score       = '0;

    if (cfg_valid && cfg_ready) begin
      base_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          rule_nxt.id     = in_item.rule_id;
          rule_nxt.mask   = in_item.rule_mask;
          rule_nxt.remote = in_item.rule_remote;
          last_nxt        = in_item.last_rule;
          j_nxt           = '0;
          state_nxt       = S_FINISH;
          if (in_item.rule_active) begin
            if (in_item.rule_remote) begin
              need_rm_nxt = 1'b1;
            end else begin
              need_d_nxt = 1'b1;
            end
            if (!failed_r) begin
              state_nxt = S_SCAN_RD;
            end
          end
        end
      end

      S_FINISH: begin
        if (last_r) begin
          // fallback when compilation failed or nothing was compiled
          fb_nxt = failed_r || (cnt_r == '0);
          nd_nxt = need_d_r || !need_rm_r;
          if (failed_r || (cnt_r == '0)) begin
            n_nxt = CW'(need_d_r || !need_rm_r) + CW'(need_rm_r);
          end else begin
            n_nxt = cnt_r;
          end
          ei_nxt    = '0;
          ek_nxt    = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // covered / covering scan
      S_SCAN_RD: begin
        if (j_r < cnt_r) begin
          raddr     = j_r[IW-1:0];
          state_nxt = S_SCAN_EV;
        end else if (cnt_r < BANKS_C) begin
          we        = 1'b1;
          waddr     = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FINISH;
        end else begin
          j_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_BEST_RD;
        end
      end

      S_SCAN_EV: begin
        if (cmf_pkg::covers(rdata, rule_r)) begin
          state_nxt = S_FINISH;
        end else if (cmf_pkg::covers(rule_r, rdata)) begin
          we         = 1'b1;
          waddr      = j_r[IW-1:0];
          i_nxt      = '0;
          append_nxt = 1'b0;
          state_nxt  = S_CI_RD;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      // table full: best same-type filter for the rule
      S_BEST_RD: begin
        if (j_r < cnt_r) begin
          raddr     = j_r[IW-1:0];
          state_nxt = S_BEST_EV;
        end else if (found_r) begin
          we         = 1'b1;
          waddr      = bl_r;
          wdata      = cmf_pkg::merge_into(ba_r, rule_r);
          i_nxt      = '0;
          append_nxt = 1'b0;
          state_nxt  = S_CI_RD;
        end else begin
          i_nxt     = '0;
          state_nxt = S_PA_RD;
        end
      end

      S_BEST_EV: begin
        score = cmf_pkg::pop(cmf_pkg::merged_mask(rdata, rule_r));
        if ((rdata.remote == rule_r.remote) && (!found_r || (score > bs_r))) begin
          found_nxt = 1'b1;
          bl_nxt    = j_r[IW-1:0];
          bs_nxt    = score;
          ba_nxt    = rdata;
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = S_BEST_RD;
      end

      // best same-type pair of filters
      S_PA_RD: begin
        if (i_r < cnt_r) begin
          raddr     = i_r[IW-1:0];
          j_nxt     = i_r + CW'(1);
          state_nxt = S_PA_LD;
        end else if (found_r) begin
          we        = 1'b1;
          waddr     = bl_r;
          wdata     = cmf_pkg::merge_into(ba_r, bb_r);
          rmk_nxt   = br_r;
          rmret_nxt = R_PAIR;
          state_nxt = S_RM;
        end else begin
          failed_nxt = 1'b1;
          state_nxt  = S_FINISH;
        end
      end

      S_PA_LD: begin
        a_nxt     = rdata;
        state_nxt = S_PB_RD;
      end

      S_PB_RD: begin
        if (j_r < cnt_r) begin
          raddr     = j_r[IW-1:0];
          state_nxt = S_PB_EV;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_PA_RD;
        end
      end

      S_PB_EV: begin
        score = cmf_pkg::pop(cmf_pkg::merged_mask(a_r, rdata));
        if ((a_r.remote == rdata.remote) && (!found_r || (score > bs_r))) begin
          found_nxt = 1'b1;
          bl_nxt    = i_r[IW-1:0];
          br_nxt    = j_r[IW-1:0];
          bs_nxt    = score;
          ba_nxt    = a_r;
          bb_nxt    = rdata;
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = S_PB_RD;
      end

      // remove entry rmk: last entry moves into its place
      S_RM: begin
        cnt_nxt = cnt_dec;
        if (CW'(rmk_r) != cnt_dec) begin
          raddr     = cnt_dec[IW-1:0];
          state_nxt = S_RM_WR;
        end else begin
          state_nxt = S_RM_WR;
        end
      end

      S_RM_WR: begin
        if (CW'(rmk_r) != cnt_r) begin
          we    = 1'b1;
          waddr = rmk_r;
          wdata = rdata;
        end
        case (rmret_r)
          R_PAIR: begin
            i_nxt      = '0;
            append_nxt = 1'b1;
            state_nxt  = S_CI_RD;
          end
          R_CJ:    state_nxt = S_CJ_RD;
          R_CI:    state_nxt = S_CI_RD;
          default: state_nxt = S_CI_RD;
        endcase
      end

      // compaction pass
      S_CI_RD: begin
        if (i_r < cnt_r) begin
          raddr     = i_r[IW-1:0];
          j_nxt     = i_r + CW'(1);
          state_nxt = S_CI_LD;
        end else begin
          if (append_r) begin
            we      = 1'b1;
            waddr   = cnt_r[IW-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end
          state_nxt = S_FINISH;
        end
      end

      S_CI_LD: begin
        a_nxt     = rdata;
        state_nxt = S_CJ_RD;
      end

      S_CJ_RD: begin
        if (j_r < cnt_r) begin
          raddr     = j_r[IW-1:0];
          state_nxt = S_CJ_EV;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_CI_RD;
        end
      end

      S_CJ_EV: begin
        if (cmf_pkg::covers(a_r, rdata)) begin
          rmk_nxt   = j_r[IW-1:0];
          rmret_nxt = R_CJ;
          state_nxt = S_RM;
        end else if (cmf_pkg::covers(rdata, a_r)) begin
          rmk_nxt   = i_r[IW-1:0];
          rmret_nxt = R_CI;
          state_nxt = S_RM;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_CJ_RD;
        end
      end

      // bank output, cycling through the filters
      S_EM_RD: begin
        raddr     = ek_r;
        state_nxt = S_EM_OUT;
      end

      S_EM_OUT: begin
        ov_nxt               = 1'b1;
        oi_nxt.bank_index    = cmf_pkg::BIDX_W'(base_r) + cmf_pkg::BIDX_W'(ei_r);
        oi_nxt.fallback_used = fb_r;
        oi_nxt.last_bank     = (ei_r == IW'(cmf_pkg::BANKS - 1));
        if (fb_r) begin
          oi_nxt.filter_id     = '0;
          oi_nxt.filter_mask   = '0;
          oi_nxt.filter_remote = (ek_r != '0) || !nd_r;
        end else begin
          oi_nxt.filter_id     = rdata.id;
          oi_nxt.filter_mask   = rdata.mask;
          oi_nxt.filter_remote = rdata.remote;
        end
        if (CW'(ek_r) + CW'(1) == n_r) begin
          ek_nxt = '0;
        end else begin
          ek_nxt = ek_r + IW'(1);
        end
        ei_nxt = ei_r + IW'(1);
        if (ei_r == IW'(cmf_pkg::BANKS - 1)) begin
          // start a new, empty rule set
          cnt_nxt     = '0;
          need_d_nxt  = 1'b0;
          need_rm_nxt = 1'b0;
          failed_nxt  = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      base_r    <= '0;
      cnt_r     <= '0;
      need_d_r  <= 1'b0;
      need_rm_r <= 1'b0;
      failed_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      cnt_r     <= cnt_nxt;
      need_d_r  <= need_d_nxt;
      need_rm_r <= need_rm_nxt;
      failed_r  <= failed_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rule_r   <= rule_nxt;
    last_r   <= last_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    a_r      <= a_nxt;
    found_r  <= found_nxt;
    bl_r     <= bl_nxt;
    br_r     <= br_nxt;
    bs_r     <= bs_nxt;
    ba_r     <= ba_nxt;
    bb_r     <= bb_nxt;
    append_r <= append_nxt;
    rmk_r    <= rmk_nxt;
    rmret_r  <= rmret_nxt;
    fb_r     <= fb_nxt;
    nd_r     <= nd_nxt;
    n_r      <= n_nxt;
    ei_r     <= ei_nxt;
    ek_r     <= ek_nxt;
    oi_r     <= oi_nxt;
  end

endmodule

`default_nettype wire

[sv/cmf_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/cmf_checker.sv]
// port-level checks for the mask filter compiler, bound to the top level
// uses cmf_pkg and can_mask_filter_compiler_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "can_mask_filter_compiler_defines.svh"

module cmf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire cmf_pkg::out_item_t out_item
);

  // fallback entries always accept every identifier of their frame type
  logic fb_open;
  assign fb_open = (out_item.filter_mask == '0) && (out_item.filter_id == '0);

  `CMF_ASSERT_NEXT(a_goes_busy, start && !busy, busy)
  `CMF_ASSERT_NOW(a_busy_mid_set, out_valid && !out_item.last_bank, busy)
  `CMF_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid)
  `CMF_ASSERT_NOW(a_fallback_open, out_valid && out_item.fallback_used, fb_open)

endmodule

bind can_mask_filter_compiler cmf_checker u_cmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
